>>> rtl/cpsb_pkg.sv
package cpsb_pkg;

    // palette and framebuffer sizing
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int ADDR_BITS       = 22;
    localparam int MAX_SPRITE_DIM  = 1024;

    // field and internal widths
    localparam int IDX_W    = 8;
    localparam int COLOR_W  = 24;
    localparam int POS_W    = 12;
    localparam int OFS_W    = 10;
    localparam int CLIP_W   = 12;
    localparam int DIM_W    = 11;
    localparam int CNT_W    = $clog2(MAX_SPRITE_DIM);
    localparam int DCMP_W   = ((CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W) + 1;
    localparam int ORG_W    = POS_W + 1;
    localparam int COORD_W  = ORG_W + 1;
    localparam int PROD_W   = 2 * CLIP_W;
    localparam int CFG_IW   = 3;

    // opcodes
    localparam logic [1:0] OP_PALETTE = 2'd0;
    localparam logic [1:0] OP_BEGIN   = 2'd1;
    localparam logic [1:0] OP_PIXEL   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_DEST_WIDTH    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CLIP_LEFT     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_CLIP_RIGHT    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_CLIP_TOP      = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CLIP_BOTTOM   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_SPRITE_WIDTH  = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_SPRITE_HEIGHT = 3'd6;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [IDX_W-1:0]         pixel_index;
        logic [COLOR_W-1:0]       palette_color;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [OFS_W-1:0]         offset_x;
        logic [OFS_W-1:0]         offset_y;
    } t_in_item;

    typedef struct packed {
        logic                 write_enable;
        logic [ADDR_BITS-1:0] write_address;
        logic [COLOR_W-1:0]   pixel_color;
        logic                 last_pixel;
    } t_out_item;

    typedef struct packed {
        logic [CLIP_W-1:0] dest_width;
        logic [CLIP_W-1:0] clip_left;
        logic [CLIP_W-1:0] clip_right;
        logic [CLIP_W-1:0] clip_top;
        logic [CLIP_W-1:0] clip_bottom;
        logic [DIM_W-1:0]  sprite_width;
        logic [DIM_W-1:0]  sprite_height;
    } t_cfg;

    // pixel descriptor leaving the raster stage
    typedef struct packed {
        logic              we;
        logic              pal_hit;
        logic [CLIP_W-1:0] col;
        logic [CLIP_W-1:0] row;
        logic              last;
    } t_pix_info;

endpackage

>>> rtl/cpsb_palette.sv
module cpsb_palette
    import cpsb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [PAL_AW-1:0]  i_waddr,
    input  logic [COLOR_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [PAL_AW-1:0]  i_raddr,
    output logic [COLOR_W-1:0] o_rdata
);

    logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0] r_rdata;

    // single write port, registered read port that holds while stalled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cpsb_raster.sv
module cpsb_raster
    import cpsb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_accept,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_pix_info o_pix
);

    logic signed [ORG_W-1:0] r_origin_col, n_origin_col;
    logic signed [ORG_W-1:0] r_origin_row, n_origin_row;
    logic [CNT_W-1:0]        r_col_cnt, n_col_cnt;
    logic [CNT_W-1:0]        r_row_cnt, n_row_cnt;
    logic                    r_valid;
    t_pix_info               r_pix;

    logic [DCMP_W-1:0]         w_eff, h_eff;
    logic [DCMP_W-1:0]         col_p1, row_p1;
    logic                      col_wrap, row_wrap;
    logic signed [COORD_W-1:0] col, row;
    logic                      visible;
    logic                      is_pixel;
    t_pix_info                 pix;

    // clamp sprite size into 1..max
    always_comb begin
        priority if (i_cfg.sprite_width == '0) begin
            w_eff = DCMP_W'(1);
        end else if (DCMP_W'(i_cfg.sprite_width) > DCMP_W'(MAX_SPRITE_DIM)) begin
            w_eff = DCMP_W'(MAX_SPRITE_DIM);
        end else begin
            w_eff = DCMP_W'(i_cfg.sprite_width);
        end
        priority if (i_cfg.sprite_height == '0) begin
            h_eff = DCMP_W'(1);
        end else if (DCMP_W'(i_cfg.sprite_height) > DCMP_W'(MAX_SPRITE_DIM)) begin
            h_eff = DCMP_W'(MAX_SPRITE_DIM);
        end else begin
            h_eff = DCMP_W'(i_cfg.sprite_height);
        end
    end

    // counter wrap detection
    assign col_p1   = DCMP_W'(r_col_cnt) + DCMP_W'(1);
    assign row_p1   = DCMP_W'(r_row_cnt) + DCMP_W'(1);
    assign col_wrap = (col_p1 >= w_eff);
    assign row_wrap = (row_p1 >= h_eff);

    // screen coordinate and clip test
    assign col = COORD_W'(r_origin_col) + $signed(COORD_W'(r_col_cnt));
    assign row = COORD_W'(r_origin_row) + $signed(COORD_W'(r_row_cnt));
    assign visible = (col >= $signed(COORD_W'(i_cfg.clip_left)))  &&
                     (col <  $signed(COORD_W'(i_cfg.clip_right))) &&
                     (row >= $signed(COORD_W'(i_cfg.clip_top)))   &&
                     (row <  $signed(COORD_W'(i_cfg.clip_bottom)));

    assign is_pixel = (i_item.opcode == OP_PIXEL);

    always_comb begin
        pix.we      = visible && (i_item.pixel_index != '0);
        pix.pal_hit = ({1'b0, i_item.pixel_index} < (IDX_W + 1)'(PALETTE_ENTRIES));
        pix.col     = col[CLIP_W-1:0];
        pix.row     = row[CLIP_W-1:0];
        pix.last    = col_wrap && row_wrap;
    end

    // origin and counter updates per accepted transaction
    always_comb begin
        n_origin_col = r_origin_col;
        n_origin_row = r_origin_row;
        n_col_cnt    = r_col_cnt;
        n_row_cnt    = r_row_cnt;
        if (i_accept) begin
            unique case (i_item.opcode)
                OP_BEGIN: begin
                    n_origin_col = ORG_W'(i_item.pos_x) + $signed(ORG_W'(i_item.offset_x));
                    n_origin_row = ORG_W'(i_item.pos_y) + $signed(ORG_W'(i_item.offset_y));
                    n_col_cnt    = '0;
                    n_row_cnt    = '0;
                end
                OP_PIXEL: begin
                    if (col_wrap) begin
                        n_col_cnt = '0;
                        n_row_cnt = row_wrap ? '0 : row_p1[CNT_W-1:0];
                    end else begin
                        n_col_cnt = col_p1[CNT_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_col <= '0;
            r_origin_row <= '0;
            r_col_cnt    <= '0;
            r_row_cnt    <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_origin_col <= n_origin_col;
            r_origin_row <= n_origin_row;
            r_col_cnt    <= n_col_cnt;
            r_row_cnt    <= n_row_cnt;
            if (i_adv) begin
                r_valid <= i_accept && is_pixel;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pix <= pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

>>> rtl/clipped_palette_sprite_blit.sv
// Indexed sprite blitter: palette-write, begin and pixel transactions enter on the input
// channel; every pixel transaction gives exactly one output transaction carrying write
// enable, framebuffer address, palette color and a last flag, in order. The block takes
// one input transaction per clock and keeps that rate as long as the output side takes
// one per clock; a pixel's result passes the palette read and raster registers, the row
// by width multiply register and the output register with the address add. A stalled
// output holds the whole pipeline and drops input ready the same cycle. The palette comes
// up undefined, so each entry must be written before a pixel uses it. Configuration
// registers are always ready and must only be written while the block is idle; the block does not enforce this.
module clipped_palette_sprite_blit
    import cpsb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CLIP_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    logic      adv;
    logic      accept;
    logic      pal_we;
    logic      s1_valid;
    t_pix_info s1_pix;
    logic [COLOR_W-1:0] pal_rdata;

    logic               r2_valid;
    logic               r2_we;
    logic               r2_last;
    logic [PROD_W-1:0]  r2_prod;
    logic [CLIP_W-1:0]  r2_col;
    logic [COLOR_W-1:0] r2_color;

    logic              r_out_valid;
    t_out_item         r_out;
    logic [PROD_W:0]   addr_sum;

    // pipeline advances unless the output register holds an untaken transaction
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_width    <= CLIP_W'(512);
            r_cfg.clip_left     <= '0;
            r_cfg.clip_right    <= CLIP_W'(512);
            r_cfg.clip_top      <= '0;
            r_cfg.clip_bottom   <= CLIP_W'(334);
            r_cfg.sprite_width  <= DIM_W'(1);
            r_cfg.sprite_height <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEST_WIDTH:    r_cfg.dest_width    <= i_cfg_data;
                CFG_CLIP_LEFT:     r_cfg.clip_left     <= i_cfg_data;
                CFG_CLIP_RIGHT:    r_cfg.clip_right    <= i_cfg_data;
                CFG_CLIP_TOP:      r_cfg.clip_top      <= i_cfg_data;
                CFG_CLIP_BOTTOM:   r_cfg.clip_bottom   <= i_cfg_data;
                CFG_SPRITE_WIDTH:  r_cfg.sprite_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SPRITE_HEIGHT: r_cfg.sprite_height <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // palette store, written by palette transactions, read for every accepted one
    assign pal_we = accept && (i_in_data.opcode == OP_PALETTE) &&
                    ({1'b0, i_in_data.pixel_index} < (IDX_W + 1)'(PALETTE_ENTRIES));

    cpsb_palette u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_in_data.pixel_index[PAL_AW-1:0]),
        .i_wdata (i_in_data.palette_color),
        .i_re    (accept),
        .i_raddr (i_in_data.pixel_index[PAL_AW-1:0]),
        .o_rdata (pal_rdata)
    );

    // origin, counters and clip test
    cpsb_raster u_raster (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_accept (accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_valid  (s1_valid),
        .o_pix    (s1_pix)
    );

    // stage two: row times width, palette color capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_we    <= s1_pix.we;
            r2_last  <= s1_pix.last;
            r2_col   <= s1_pix.col;
            r2_prod  <= PROD_W'(s1_pix.row) * PROD_W'(r_cfg.dest_width);
            r2_color <= s1_pix.pal_hit ? pal_rdata : '0;
        end
    end

    // stage three: address add into the output register
    assign addr_sum = (PROD_W + 1)'(r2_prod) + (PROD_W + 1)'(r2_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.write_enable  <= r2_we;
            r_out.write_address <= r2_we ? addr_sum[ADDR_BITS-1:0] : '0;
            r_out.pixel_color   <= r2_we ? r2_color : '0;
            r_out.last_pixel    <= r2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
